// ===== hw/rtl/hcrd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the entity name ROM for the character reference decoder.
package hcrd_pkg;

  localparam int unsigned NameTableDepth = 256;
  localparam int unsigned IdxW = 8;
  localparam int unsigned OutCap = 27;
  localparam int unsigned OcntW = 5;
  localparam logic [20:0] CpLimit = 21'h10FFFF;

  // parse modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_AMP  = 3'd1;
  localparam logic [2:0] MODE_HASH = 3'd2;
  localparam logic [2:0] MODE_DEC  = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;
  localparam logic [2:0] MODE_NAME = 3'd5;

  // emit sources
  localparam logic [1:0] SRC_BYTE  = 2'd0;
  localparam logic [1:0] SRC_SPILL = 2'd1;
  localparam logic [1:0] SRC_UTF   = 2'd2;

  typedef struct packed {
    logic       ld;
    logic       hold;
    logic       acc;
    logic       hex;
    logic       set_mode;
    logic [2:0] mode;
    logic       close;
    logic       idx_clr;
    logic       idx_inc;
    logic       emit;
    logic [1:0] src;
    logic       fin;
    logic       ld_cp;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       is_amp;
    logic       is_semi;
    logic       is_hash;
    logic       is_x;
    logic       dig_dec;
    logic       dig_hex;
    logic       full;
    logic       too_big;
    logic       spill_last;
    logic       utf_last;
    logic       hit;
    logic       rom_last;
    logic       out_free;
    logic       pend_valid;
    logic       b_last;
  } status_t;

  typedef struct packed {
    logic [63:0] name;  // right aligned, last char in the low byte
    logic [13:0] cp;
  } ent_t;

  function automatic ent_t ent_lookup(input logic [IdxW-1:0] i);
    ent_t r;
    r = '{64'd0, 14'd0};
    case (i)
      0: r='{"AElig",198}; 1: r='{"Aacute",193}; 2: r='{"Acirc",194};
      3: r='{"Agrave",192}; 4: r='{"Alpha",913}; 5: r='{"Aring",197};
      6: r='{"Atilde",195}; 7: r='{"Auml",196}; 8: r='{"Beta",914};
      9: r='{"Ccedil",199}; 10: r='{"Chi",935}; 11: r='{"Dagger",8225};
      12: r='{"Delta",916}; 13: r='{"ETH",208}; 14: r='{"Eacute",201};
      15: r='{"Ecirc",202}; 16: r='{"Egrave",200}; 17: r='{"Epsilon",917};
      18: r='{"Eta",919}; 19: r='{"Euml",203}; 20: r='{"Gamma",915};
      21: r='{"Iacute",205}; 22: r='{"Icirc",206}; 23: r='{"Igrave",204};
      24: r='{"Iota",921}; 25: r='{"Iuml",207}; 26: r='{"Kappa",922};
      27: r='{"Lambda",923}; 28: r='{"Mu",924}; 29: r='{"Ntilde",209};
      30: r='{"Nu",925}; 31: r='{"OElig",338}; 32: r='{"Oacute",211};
      33: r='{"Ocirc",212}; 34: r='{"Ograve",210}; 35: r='{"Omega",937};
      36: r='{"Omicron",927}; 37: r='{"Oslash",216}; 38: r='{"Otilde",213};
      39: r='{"Ouml",214}; 40: r='{"Phi",934}; 41: r='{"Pi",928};
      42: r='{"Prime",8243}; 43: r='{"Psi",936}; 44: r='{"Rho",929};
      45: r='{"Scaron",352}; 46: r='{"Sigma",931}; 47: r='{"THORN",222};
      48: r='{"Tau",932}; 49: r='{"Theta",920}; 50: r='{"Uacute",218};
      51: r='{"Ucirc",219}; 52: r='{"Ugrave",217}; 53: r='{"Upsilon",933};
      54: r='{"Uuml",220}; 55: r='{"Xi",926}; 56: r='{"Yacute",221};
      57: r='{"Yuml",376}; 58: r='{"Zeta",918}; 59: r='{"aacute",225};
      60: r='{"acirc",226}; 61: r='{"acute",180}; 62: r='{"aelig",230};
      63: r='{"agrave",224}; 64: r='{"alefsym",8501}; 65: r='{"alpha",945};
      66: r='{"amp",38}; 67: r='{"and",8743}; 68: r='{"ang",8736};
      69: r='{"apos",39}; 70: r='{"aring",229}; 71: r='{"asymp",8776};
      72: r='{"atilde",227}; 73: r='{"auml",228}; 74: r='{"bdquo",8222};
      75: r='{"beta",946}; 76: r='{"brvbar",166}; 77: r='{"bull",8226};
      78: r='{"cap",8745}; 79: r='{"ccedil",231}; 80: r='{"cedil",184};
      81: r='{"cent",162}; 82: r='{"chi",967}; 83: r='{"circ",710};
      84: r='{"clubs",9827}; 85: r='{"cong",8773}; 86: r='{"copy",169};
      87: r='{"crarr",8629}; 88: r='{"cup",8746}; 89: r='{"curren",164};
      90: r='{"dArr",8659}; 91: r='{"dagger",8224}; 92: r='{"darr",8595};
      93: r='{"deg",176}; 94: r='{"delta",948}; 95: r='{"diams",9830};
      96: r='{"divide",247}; 97: r='{"eacute",233}; 98: r='{"ecirc",234};
      99: r='{"egrave",232}; 100: r='{"empty",8709}; 101: r='{"emsp",8195};
      102: r='{"ensp",8194}; 103: r='{"epsilon",949}; 104: r='{"equiv",8801};
      105: r='{"eta",951}; 106: r='{"eth",240}; 107: r='{"euml",235};
      108: r='{"euro",8364}; 109: r='{"exist",8707}; 110: r='{"fnof",402};
      111: r='{"forall",8704}; 112: r='{"frac12",189}; 113: r='{"frac14",188};
      114: r='{"frac34",190}; 115: r='{"frasl",8260}; 116: r='{"gamma",947};
      117: r='{"ge",8805}; 118: r='{"gt",62}; 119: r='{"hArr",8660};
      120: r='{"harr",8596}; 121: r='{"hearts",9829}; 122: r='{"hellip",8230};
      123: r='{"iacute",237}; 124: r='{"icirc",238}; 125: r='{"iexcl",161};
      126: r='{"igrave",236}; 127: r='{"image",8465}; 128: r='{"infin",8734};
      129: r='{"int",8747}; 130: r='{"iota",953}; 131: r='{"iquest",191};
      132: r='{"isin",8712}; 133: r='{"iuml",239}; 134: r='{"kappa",954};
      135: r='{"lArr",8656}; 136: r='{"lambda",955}; 137: r='{"lang",9001};
      138: r='{"laquo",171}; 139: r='{"larr",8592}; 140: r='{"lceil",8968};
      141: r='{"ldquo",8220}; 142: r='{"le",8804}; 143: r='{"lfloor",8970};
      144: r='{"lowast",8727}; 145: r='{"loz",9674}; 146: r='{"lrm",8206};
      147: r='{"lsaquo",8249}; 148: r='{"lsquo",8216}; 149: r='{"lt",60};
      150: r='{"macr",175}; 151: r='{"mdash",8212}; 152: r='{"micro",181};
      153: r='{"middot",183}; 154: r='{"minus",8722}; 155: r='{"mu",956};
      156: r='{"nabla",8711}; 157: r='{"nbsp",160}; 158: r='{"ndash",8211};
      159: r='{"ne",8800}; 160: r='{"ni",8715}; 161: r='{"not",172};
      162: r='{"notin",8713}; 163: r='{"nsub",8836}; 164: r='{"ntilde",241};
      165: r='{"nu",957}; 166: r='{"oacute",243}; 167: r='{"ocirc",244};
      168: r='{"oelig",339}; 169: r='{"ograve",242}; 170: r='{"oline",8254};
      171: r='{"omega",969}; 172: r='{"omicron",959}; 173: r='{"oplus",8853};
      174: r='{"or",8744}; 175: r='{"ordf",170}; 176: r='{"ordm",186};
      177: r='{"oslash",248}; 178: r='{"otilde",245}; 179: r='{"otimes",8855};
      180: r='{"ouml",246}; 181: r='{"para",182}; 182: r='{"part",8706};
      183: r='{"permil",8240}; 184: r='{"perp",8869}; 185: r='{"phi",966};
      186: r='{"pi",960}; 187: r='{"piv",982}; 188: r='{"plusmn",177};
      189: r='{"pound",163}; 190: r='{"prime",8242}; 191: r='{"prod",8719};
      192: r='{"prop",8733}; 193: r='{"psi",968}; 194: r='{"quot",34};
      195: r='{"rArr",8658}; 196: r='{"radic",8730}; 197: r='{"rang",9002};
      198: r='{"raquo",187}; 199: r='{"rarr",8594}; 200: r='{"rceil",8969};
      201: r='{"rdquo",8221}; 202: r='{"real",8476}; 203: r='{"reg",174};
      204: r='{"rfloor",8971}; 205: r='{"rho",961}; 206: r='{"rlm",8207};
      207: r='{"rsaquo",8250}; 208: r='{"rsquo",8217}; 209: r='{"sbquo",8218};
      210: r='{"scaron",353}; 211: r='{"sdot",8901}; 212: r='{"sect",167};
      213: r='{"shy",173}; 214: r='{"sigma",963}; 215: r='{"sigmaf",962};
      216: r='{"sim",8764}; 217: r='{"spades",9824}; 218: r='{"sub",8834};
      219: r='{"sube",8838}; 220: r='{"sum",8721}; 221: r='{"sup1",185};
      222: r='{"sup2",178}; 223: r='{"sup3",179}; 224: r='{"sup",8835};
      225: r='{"supe",8839}; 226: r='{"szlig",223}; 227: r='{"tau",964};
      228: r='{"there4",8756}; 229: r='{"theta",952}; 230: r='{"thetasym",977};
      231: r='{"thinsp",8201}; 232: r='{"thorn",254}; 233: r='{"tilde",732};
      234: r='{"times",215}; 235: r='{"trade",8482}; 236: r='{"uArr",8657};
      237: r='{"uacute",250}; 238: r='{"uarr",8593}; 239: r='{"ucirc",251};
      240: r='{"ugrave",249}; 241: r='{"uml",168}; 242: r='{"upsih",978};
      243: r='{"upsilon",965}; 244: r='{"uuml",252}; 245: r='{"weierp",8472};
      246: r='{"xi",958}; 247: r='{"yacute",253}; 248: r='{"yen",165};
      249: r='{"yuml",255}; 250: r='{"zeta",950}; 251: r='{"zwj",8205};
      252: r='{"zwnj",8204};
      default: r = '{64'd0, 14'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/hcrd_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: held bytes, code accumulator, name compare, UTF-8 encode, output stage.
module hcrd_datapath #(
  parameter int unsigned MAX_REF_LEN = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hcrd_pkg::cmd_t   cmd_i,
  output hcrd_pkg::status_t st_o,
  input  logic [7:0]       s_axis_tdata_i,
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic [0:0]       m_axis_tuser_o
);
  import hcrd_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_REF_LEN + 1);
  localparam int unsigned HidxW = $clog2(MAX_REF_LEN);

  logic [7:0]      b_q;
  logic            blast_q;
  logic [2:0]      mode_q, mode_d;
  logic [7:0]      held_q [MAX_REF_LEN];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [20:0]     acc_q, acc_d;
  logic            big_q, big_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      pend_q;
  logic            pend_v_q, pend_v_d;
  logic [OcntW-1:0] ocnt_q, ocnt_d;
  logic [7:0]      out_q;
  logic            out_v_q, out_v_d;
  logic            olast_q, oend_q;

  logic [4:0]  dig;
  logic [24:0] acc_next;
  logic        acc_over;
  logic [1:0]  nm1;
  logic [7:0]  utf_byte, spill_byte, ebyte;
  logic [IdxW-1:0] idx_m1;
  ent_t        ent;
  logic [3:0]  nlen;
  logic        mism;
  logic [2:0]  pos;
  logic [7:0]  nb;
  logic        out_free, emit_ok, push_emit, push_fin;

  always_comb begin
    if (b_q >= "0" && b_q <= "9") dig = {1'b0, b_q[3:0]} - 5'd0;
    else if (b_q >= "a" && b_q <= "f") dig = 5'(b_q - 8'd87);
    else if (b_q >= "A" && b_q <= "F") dig = 5'(b_q - 8'd55);
    else dig = 5'd16;
  end

  // acc * base + digit, saturating at the code point limit
  always_comb begin
    if (cmd_i.hex) acc_next = {acc_q, 4'b0} + 25'(dig[3:0]);
    else acc_next = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + 25'(dig[3:0]);
    acc_over = acc_next > 25'(CpLimit);
  end

  always_comb begin
    if (acc_q <= 21'h7F) nm1 = 2'd0;
    else if (acc_q <= 21'h7FF) nm1 = 2'd1;
    else if (acc_q <= 21'hFFFF) nm1 = 2'd2;
    else nm1 = 2'd3;
    utf_byte = 8'h00;
    case (nm1)
      2'd0: utf_byte = acc_q[7:0];
      2'd1: utf_byte = (idx_q[1:0] == 2'd0) ? {3'b110, acc_q[10:6]} : {2'b10, acc_q[5:0]};
      2'd2: begin
        case (idx_q[1:0])
          2'd0:    utf_byte = {4'b1110, acc_q[15:12]};
          2'd1:    utf_byte = {2'b10, acc_q[11:6]};
          default: utf_byte = {2'b10, acc_q[5:0]};
        endcase
      end
      default: begin
        case (idx_q[1:0])
          2'd0:    utf_byte = {5'b11110, acc_q[20:18]};
          2'd1:    utf_byte = {2'b10, acc_q[17:12]};
          2'd2:    utf_byte = {2'b10, acc_q[11:6]};
          default: utf_byte = {2'b10, acc_q[5:0]};
        endcase
      end
    endcase
  end

  // spill beat 0 is the ampersand, beat j is held byte j-1
  assign idx_m1 = idx_q - IdxW'(1);
  assign spill_byte = (idx_q == '0) ? "&" : held_q[idx_m1[HidxW-1:0]];

  always_comb begin
    case (cmd_i.src)
      SRC_SPILL: ebyte = spill_byte;
      SRC_UTF:   ebyte = utf_byte;
      default:   ebyte = b_q;
    endcase
  end

  // name compare against one ROM entry per cycle
  always_comb begin
    ent  = ent_lookup(idx_q);
    nlen = 4'd0;
    mism = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (ent.name[8*k +: 8] != 8'd0) nlen = 4'(k + 1);
    end
    for (int k = 0; k < 8; k++) begin
      pos = 3'(nlen - 4'd1 - 4'(k));
      nb  = ent.name[8*pos +: 8];
      if (4'(k) < nlen && held_q[k] != nb) mism = 1'b1;
    end
  end

  assign out_free  = !out_v_q || m_axis_tready_i;
  assign emit_ok   = ocnt_q < OcntW'(OutCap);
  assign push_emit = cmd_i.emit && emit_ok && pend_v_q;
  assign push_fin  = cmd_i.fin && pend_v_q;

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    big_d  = big_q;
    if (cmd_i.close) begin
      mode_d = MODE_IDLE;
      cnt_d  = '0;
      acc_d  = '0;
      big_d  = 1'b0;
    end
    if (cmd_i.set_mode) mode_d = cmd_i.mode;
    if (cmd_i.hold) cnt_d = cnt_q + CntW'(1);
    if (cmd_i.acc) begin
      acc_d = acc_over ? CpLimit : acc_next[20:0];
      if (acc_over) big_d = 1'b1;
    end
    if (cmd_i.ld_cp) acc_d = {7'b0, ent.cp};

    idx_d = idx_q;
    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = idx_q + IdxW'(1);

    pend_v_d = pend_v_q;
    ocnt_d   = ocnt_q;
    if (cmd_i.ld) ocnt_d = '0;
    if (cmd_i.emit && emit_ok) begin
      pend_v_d = 1'b1;
      ocnt_d   = ocnt_q + OcntW'(1);
    end
    if (cmd_i.fin) pend_v_d = 1'b0;

    if (push_emit || push_fin) out_v_d = 1'b1;
    else if (m_axis_tready_i) out_v_d = 1'b0;
    else out_v_d = out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      cnt_q    <= '0;
      acc_q    <= '0;
      big_q    <= 1'b0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      ocnt_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      big_q    <= big_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      ocnt_q   <= ocnt_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      b_q     <= s_axis_tdata_i;
      blast_q <= s_axis_tlast_i;
    end
    if (cmd_i.hold) held_q[cnt_q[HidxW-1:0]] <= b_q;
    if (cmd_i.emit && emit_ok) pend_q <= ebyte;
    if (push_emit) begin
      out_q   <= pend_q;
      olast_q <= 1'b0;
      oend_q  <= 1'b0;
    end else if (push_fin) begin
      out_q   <= pend_q;
      olast_q <= 1'b1;
      oend_q  <= blast_q;
    end
  end

  assign st_o.mode       = mode_q;
  assign st_o.is_amp     = b_q == "&";
  assign st_o.is_semi    = b_q == ";";
  assign st_o.is_hash    = b_q == "#";
  assign st_o.is_x       = b_q == "x" || b_q == "X";
  assign st_o.dig_dec    = dig < 5'd10;
  assign st_o.dig_hex    = dig < 5'd16;
  assign st_o.full       = cnt_q >= CntW'(MAX_REF_LEN);
  assign st_o.too_big    = big_q;
  assign st_o.spill_last = idx_q == IdxW'(cnt_q);
  assign st_o.utf_last   = idx_q[1:0] == nm1;
  assign st_o.hit        = nlen != 4'd0 && cnt_q == CntW'(nlen) && !mism;
  assign st_o.rom_last   = idx_q == IdxW'(NameTableDepth - 1);
  assign st_o.out_free   = out_free;
  assign st_o.pend_valid = pend_v_q;
  assign st_o.b_last     = blast_q;

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = oend_q;

endmodule

// ===== hw/rtl/hcrd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: parse decisions, spill, encode, lookup and finish sequencing.
module hcrd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  hcrd_pkg::status_t st_i,
  output hcrd_pkg::cmd_t    cmd_o
);
  import hcrd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROC  = 3'd1;
  localparam logic [2:0] S_SPILL = 3'd2;
  localparam logic [2:0] S_CODE  = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       flush_q, flush_d;

  always_comb begin
    state_d = state_q;
    flush_d = flush_q;
    cmd_o   = '0;
    s_axis_tready_o = state_q == S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.ld = 1'b1;
          state_d  = S_PROC;
        end
      end
      S_PROC: begin
        cmd_o.idx_clr = 1'b1;
        case (st_i.mode) inside
          MODE_IDLE: begin
            if (st_i.is_amp) begin
              cmd_o.close    = 1'b1;
              cmd_o.set_mode = 1'b1;
              cmd_o.mode     = MODE_AMP;
              state_d        = S_END;
            end else if (st_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.src  = SRC_BYTE;
              state_d    = S_END;
            end
          end
          MODE_AMP: begin
            cmd_o.set_mode = 1'b1;
            if (st_i.is_hash && !st_i.full) begin
              cmd_o.hold = 1'b1;
              cmd_o.mode = MODE_HASH;
              state_d    = S_END;
            end else if (!st_i.is_semi && !st_i.is_amp && !st_i.full) begin
              cmd_o.hold = 1'b1;
              cmd_o.mode = MODE_NAME;
              state_d    = S_END;
            end else begin
              cmd_o.set_mode = 1'b0;
              state_d        = S_SPILL;
            end
          end
          MODE_HASH: begin
            if (st_i.is_x && !st_i.full) begin
              cmd_o.hold     = 1'b1;
              cmd_o.set_mode = 1'b1;
              cmd_o.mode     = MODE_HEX;
              state_d        = S_END;
            end else if (st_i.is_semi) begin
              state_d = S_CODE;  // empty digit run, accumulator is zero
            end else if (st_i.dig_dec && !st_i.full) begin
              cmd_o.hold     = 1'b1;
              cmd_o.acc      = 1'b1;
              cmd_o.set_mode = 1'b1;
              cmd_o.mode     = MODE_DEC;
              state_d        = S_END;
            end else begin
              state_d = S_SPILL;
            end
          end
          MODE_DEC, MODE_HEX: begin
            cmd_o.hex = st_i.mode == MODE_HEX;
            if (st_i.is_semi) begin
              state_d = st_i.too_big ? S_SPILL : S_CODE;
            end else if ((cmd_o.hex ? st_i.dig_hex : st_i.dig_dec) && !st_i.full) begin
              cmd_o.hold = 1'b1;
              cmd_o.acc  = 1'b1;
              state_d    = S_END;
            end else begin
              state_d = S_SPILL;
            end
          end
          MODE_NAME: begin
            if (st_i.is_semi) begin
              state_d = S_LOOK;
            end else if (!st_i.is_amp && !st_i.full) begin
              cmd_o.hold = 1'b1;
              state_d    = S_END;
            end else begin
              state_d = S_SPILL;
            end
          end
          default: state_d = S_SPILL;
        endcase
      end
      S_SPILL: begin
        if (st_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.src     = SRC_SPILL;
          cmd_o.idx_inc = 1'b1;
          if (st_i.spill_last) begin
            cmd_o.close = 1'b1;
            state_d     = flush_q ? S_FIN : S_PROC;
          end
        end
      end
      S_CODE: begin
        if (st_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.src     = SRC_UTF;
          cmd_o.idx_inc = 1'b1;
          if (st_i.utf_last) begin
            cmd_o.close = 1'b1;
            state_d     = S_END;
          end
        end
      end
      S_LOOK: begin
        if (st_i.hit) begin
          cmd_o.ld_cp   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_CODE;
        end else if (st_i.rom_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_SPILL;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_END: begin
        cmd_o.idx_clr = 1'b1;
        if (st_i.b_last && st_i.mode != MODE_IDLE) begin
          flush_d = 1'b1;
          state_d = S_SPILL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (st_i.out_free || !st_i.pend_valid) begin
          cmd_o.fin = 1'b1;
          flush_d   = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

endmodule

// ===== hw/rtl/html_char_ref_decoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the HTML character reference decoder.
//
//  channel  | dir | tdata             | tlast        | tuser
//  s_axis   | in  | [7:0] in_byte     | stream_last  | -
//  m_axis   | out | [7:0] out_byte    | run_last     | [0] stream_end
//
// A text beat passes the accept, parse, wrap-up and finish states; tready is high only
// while idle. A decoded reference emits its UTF-8 bytes one at a time; a named one first
// scans the 256-entry ROM one entry a cycle, up to a hit or to the last entry on a miss.
// A failed reference replays '&' and the held bytes one per cycle while the output is free,
// then reparses the breaking byte; an end-of-stream flush replays them but then finishes.
// One byte is held back to mark run_last; a full output register stalls each emit.
// Reset is asynchronous, active low, and leaves the parser idle.
module html_char_ref_decoder_core #(
  parameter int unsigned MAX_REF_LEN = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic [0:0] m_axis_tuser_o    // [0] stream_end
);
  import hcrd_pkg::*;

  cmd_t    cmd;
  status_t st;

  hcrd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .st_i  (st),
    .cmd_o (cmd)
  );

  hcrd_datapath #(
    .MAX_REF_LEN (MAX_REF_LEN)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .st_o  (st),
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o,
    .m_axis_tuser_o
  );

endmodule
